// ===== hw/rtl/lcdr_pkg.sv =====
// Package for the character LCD refresh engine.
// Panel geometry, command/action/phase codes, controller-datapath structs, helpers.
// No dependencies.
package lcdr_pkg;

	// Panel geometry
	localparam int ROWS    = 4;
	localparam int COLUMNS = 20;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int IDX_W   = $clog2(CELLS);

	// Field widths
	localparam int ROW_W  = 2;
	localparam int COL_W  = 5;
	localparam int CHAR_W = 8;

	// Panel bus constants
	localparam logic [7:0] ADDR_HI_ADJ = 8'h6C;
	localparam logic [7:0] SET_ADDR_OP = 8'b1000_0000;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;

	// Host commands
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_SYNC  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	// Bus actions
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_INSTR = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_BUSY  = 2'd3
	} act_t;

	// Transfer phase
	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_ADDR      = 5'b00010,
		PH_ADDR_WAIT = 5'b00100,
		PH_DATA      = 5'b01000,
		PH_DATA_WAIT = 5'b10000
	} phase_t;

	// Controller to datapath commands
	typedef struct packed {
		logic init_sweep;  // write zero into all frames at sweep index
		logic fill_sweep;  // write space into user frame at sweep index
		logic copy_sweep;  // copy user frame entry to desired frame
		logic cell_wr;     // host cell write
		logic sync_set;    // mark dirty, restart scan position
		logic res_none;    // load an empty result
		logic tick_step;   // advance a transfer in progress
		logic scan_load;   // start a difference scan
		logic scan_run;    // scan one cell per cycle
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic dirty;
		logic xfer_idle;
		logic sweep_last;
		logic scan_hit;
		logic scan_miss;
	} dp_stat_t;

	// Linear cell index in row-major order
	function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return IDX_W'(int'(r) * COLUMNS + int'(c));
	endfunction

	// DDRAM address of a cell
	function automatic logic [7:0] cell_address(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		logic [7:0] a;
		a = {r, 6'b0} + {3'b0, c};
		if (r > 2'd1) begin
			a = a - ADDR_HI_ADJ;
		end
		return a;
	endfunction

endpackage

// ===== hw/rtl/lcdr_dp.sv =====
// Datapath of the LCD refresh engine: the three frame memories, sweep and scan
// counters, transfer registers and the result registers. Uses lcdr_pkg.
module lcdr_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lcdr_pkg::ctl_cmd_t       cmd,
	input  logic [lcdr_pkg::ROW_W-1:0]  row,
	input  logic [lcdr_pkg::COL_W-1:0]  col,
	input  logic [lcdr_pkg::CHAR_W-1:0] char_code,
	input  logic                     busy_flag,
	output lcdr_pkg::dp_stat_t       stat,
	output logic [1:0]               bus_action,
	output logic [7:0]               bus_data,
	output logic                     refresh_pending
);

	localparam int IW = lcdr_pkg::IDX_W;
	localparam int RW = lcdr_pkg::ROW_W;
	localparam int CW = lcdr_pkg::COL_W;

	// Frame memories
	logic [7:0] user_mem [lcdr_pkg::CELLS];
	logic [7:0] des_mem  [lcdr_pkg::CELLS];
	logic [7:0] shd_mem  [lcdr_pkg::CELLS];

	// Sweep and copy pipeline
	logic [IW-1:0] sweep_q;
	logic          cp_vld_s1;
	logic [IW-1:0] cp_idx_s1;
	logic [7:0]    user_rd_s1;

	// Scan pointer, in-flight tag and read data
	logic          ptr_vld_q;
	logic [RW-1:0] ptr_row_q;
	logic [CW-1:0] ptr_col_q;
	logic [IW-1:0] ptr_idx_q;
	logic          tag_vld_s1;
	logic [RW-1:0] tag_row_s1;
	logic [CW-1:0] tag_col_s1;
	logic [IW-1:0] tag_idx_s1;
	logic [7:0]    des_rd_s1;
	logic [7:0]    shd_rd_s1;

	// Architectural state
	logic          dirty_q;
	lcdr_pkg::phase_t phase_q;
	logic [RW-1:0] scan_row_q;
	logic [CW-1:0] scan_col_q;
	logic [IW-1:0] scan_idx_q;
	logic [7:0]    last_addr_q;
	logic [7:0]    pend_q;
	lcdr_pkg::act_t act_q;
	logic [7:0]    data_q;

	// Combinational helpers
	logic          sweep_any;
	logic          sweep_last;
	logic          cell_ok;
	logic [IW-1:0] cell_idx;
	logic          user_we;
	logic [IW-1:0] user_wa;
	logic [7:0]    user_wd;
	logic          des_we;
	logic [IW-1:0] des_wa;
	logic [7:0]    des_wd;
	logic          tag_diff;
	logic          tag_last;
	logic          scan_hit;
	logic          scan_miss;
	logic [7:0]    hit_addr;
	logic          hit_seq;
	logic          ptr_last;
	logic          issue;

	assign sweep_any  = cmd.init_sweep | cmd.fill_sweep | cmd.copy_sweep;
	assign sweep_last = (sweep_q == IW'(lcdr_pkg::CELLS - 1));

	// Host cell write decode
	assign cell_ok  = ({1'b0, row} < (RW + 1)'(lcdr_pkg::ROWS)) &&
		({1'b0, col} < (CW + 1)'(lcdr_pkg::COLUMNS));
	assign cell_idx = lcdr_pkg::cell_index(row, col);

	// User frame write port
	always_comb begin
		user_we = cmd.init_sweep | cmd.fill_sweep | (cmd.cell_wr & cell_ok);
		user_wa = cmd.cell_wr ? cell_idx : sweep_q;
		if (cmd.init_sweep) begin
			user_wd = 8'h00;
		end else if (cmd.fill_sweep) begin
			user_wd = lcdr_pkg::SPACE_CHAR;
		end else begin
			user_wd = char_code;
		end
	end

	// Desired frame write port
	assign des_we = cmd.init_sweep | cp_vld_s1;
	assign des_wa = cmd.init_sweep ? sweep_q : cp_idx_s1;
	assign des_wd = cmd.init_sweep ? 8'h00 : user_rd_s1;

	// Scan compare on the cell read last cycle
	assign tag_diff  = tag_vld_s1 && (des_rd_s1 != shd_rd_s1);
	assign tag_last  = (tag_row_s1 == RW'(lcdr_pkg::ROWS - 1)) &&
		(tag_col_s1 == CW'(lcdr_pkg::COLUMNS - 1));
	assign scan_hit  = cmd.scan_run && tag_diff;
	assign scan_miss = cmd.scan_run && tag_vld_s1 && !tag_diff && tag_last;
	assign hit_addr  = lcdr_pkg::cell_address(tag_row_s1, tag_col_s1);
	assign hit_seq   = ({1'b0, hit_addr} == ({1'b0, last_addr_q} + 9'd1));
	assign ptr_last  = (ptr_row_q == RW'(lcdr_pkg::ROWS - 1)) &&
		(ptr_col_q == CW'(lcdr_pkg::COLUMNS - 1));
	assign issue     = cmd.scan_run && ptr_vld_q;

	// User frame memory
	always_ff @(posedge clk) begin
		if (user_we) begin
			user_mem[user_wa] <= user_wd;
		end
		user_rd_s1 <= user_mem[sweep_q];
	end

	// Desired frame memory
	always_ff @(posedge clk) begin
		if (des_we) begin
			des_mem[des_wa] <= des_wd;
		end
		des_rd_s1 <= des_mem[ptr_idx_q];
	end

	// Shadow frame memory
	always_ff @(posedge clk) begin
		if (cmd.init_sweep) begin
			shd_mem[sweep_q] <= 8'h00;
		end else if (scan_hit) begin
			shd_mem[tag_idx_s1] <= des_rd_s1;
		end
		shd_rd_s1 <= shd_mem[ptr_idx_q];
	end

	// Sweep counter and copy pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			cp_vld_s1 <= 1'b0;
			cp_idx_s1 <= '0;
		end else begin
			cp_vld_s1 <= cmd.copy_sweep;
			cp_idx_s1 <= sweep_q;
			if (sweep_any) begin
				sweep_q <= sweep_last ? '0 : sweep_q + IW'(1);
			end
		end
	end

	// Scan pointer and in-flight tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q  <= 1'b0;
			ptr_row_q  <= '0;
			ptr_col_q  <= '0;
			ptr_idx_q  <= '0;
			tag_vld_s1 <= 1'b0;
			tag_row_s1 <= '0;
			tag_col_s1 <= '0;
			tag_idx_s1 <= '0;
		end else if (cmd.scan_load) begin
			ptr_vld_q  <= 1'b1;
			ptr_row_q  <= scan_row_q;
			ptr_col_q  <= scan_col_q;
			ptr_idx_q  <= scan_idx_q;
			tag_vld_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			tag_vld_s1 <= issue;
			tag_row_s1 <= ptr_row_q;
			tag_col_s1 <= ptr_col_q;
			tag_idx_s1 <= ptr_idx_q;
			if (issue) begin
				ptr_idx_q <= ptr_idx_q + IW'(1);
				if (ptr_last) begin
					ptr_vld_q <= 1'b0;
				end
				if (ptr_col_q == CW'(lcdr_pkg::COLUMNS - 1)) begin
					ptr_col_q <= '0;
					ptr_row_q <= ptr_row_q + RW'(1);
				end else begin
					ptr_col_q <= ptr_col_q + CW'(1);
				end
			end
		end
	end

	// Dirty mark, scan position, transfer phase and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q     <= 1'b0;
			phase_q     <= lcdr_pkg::PH_IDLE;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			scan_idx_q  <= '0;
			last_addr_q <= '0;
			pend_q      <= '0;
			act_q       <= lcdr_pkg::ACT_NONE;
			data_q      <= '0;
		end else begin
			if (cmd.sync_set) begin
				dirty_q    <= 1'b1;
				scan_row_q <= '0;
				scan_col_q <= '0;
				scan_idx_q <= '0;
			end
			if (cmd.res_none) begin
				act_q  <= lcdr_pkg::ACT_NONE;
				data_q <= '0;
			end
			// transfer already under way
			if (cmd.tick_step) begin
				unique case (phase_q)
					lcdr_pkg::PH_ADDR: begin
						act_q   <= lcdr_pkg::ACT_INSTR;
						data_q  <= lcdr_pkg::SET_ADDR_OP | last_addr_q;
						phase_q <= lcdr_pkg::PH_ADDR_WAIT;
					end
					lcdr_pkg::PH_DATA: begin
						act_q   <= lcdr_pkg::ACT_DATA;
						data_q  <= pend_q;
						phase_q <= lcdr_pkg::PH_DATA_WAIT;
					end
					lcdr_pkg::PH_ADDR_WAIT: begin
						act_q  <= lcdr_pkg::ACT_BUSY;
						data_q <= '0;
						if (!busy_flag) begin
							phase_q <= lcdr_pkg::PH_DATA;
						end
					end
					lcdr_pkg::PH_DATA_WAIT: begin
						act_q  <= lcdr_pkg::ACT_BUSY;
						data_q <= '0;
						if (!busy_flag) begin
							phase_q <= lcdr_pkg::PH_IDLE;
						end
					end
					default: begin
						act_q  <= lcdr_pkg::ACT_NONE;
						data_q <= '0;
					end
				endcase
			end
			// differing cell found: start its transfer at once
			if (scan_hit) begin
				scan_row_q  <= tag_row_s1;
				scan_col_q  <= tag_col_s1;
				scan_idx_q  <= tag_idx_s1;
				last_addr_q <= hit_addr;
				pend_q      <= des_rd_s1;
				if (hit_seq) begin
					act_q   <= lcdr_pkg::ACT_DATA;
					data_q  <= des_rd_s1;
					phase_q <= lcdr_pkg::PH_DATA_WAIT;
				end else begin
					act_q   <= lcdr_pkg::ACT_INSTR;
					data_q  <= lcdr_pkg::SET_ADDR_OP | hit_addr;
					phase_q <= lcdr_pkg::PH_ADDR_WAIT;
				end
			end
			// full pass with no difference
			if (scan_miss) begin
				scan_row_q <= '0;
				scan_col_q <= '0;
				scan_idx_q <= '0;
				dirty_q    <= 1'b0;
				act_q      <= lcdr_pkg::ACT_NONE;
				data_q     <= '0;
			end
		end
	end

	// Status and outputs
	assign stat.dirty      = dirty_q;
	assign stat.xfer_idle  = (phase_q == lcdr_pkg::PH_IDLE);
	assign stat.sweep_last = sweep_last;
	assign stat.scan_hit   = scan_hit;
	assign stat.scan_miss  = scan_miss;

	assign bus_action      = act_q;
	assign bus_data        = data_q;
	assign refresh_pending = dirty_q;

	// A transfer only runs while the display is marked dirty
	a_phase_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != lcdr_pkg::PH_IDLE) |-> dirty_q)
		else $error("transfer phase active while clean");

	// A scan hit always starts a transfer
	a_hit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |=> (phase_q == lcdr_pkg::PH_ADDR_WAIT ||
			phase_q == lcdr_pkg::PH_DATA_WAIT))
		else $error("scan hit without transfer");

	// Copy write stage follows a copy read
	a_copy_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> $past(cmd.copy_sweep))
		else $error("desired frame write without copy read");

endmodule

// ===== hw/rtl/lcdr_ctrl.sv =====
// Controller of the LCD refresh engine: request acceptance, reset clearing
// pass, fill/copy sweeps and difference scan sequencing. Uses lcdr_pkg.
module lcdr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          command,
	input  lcdr_pkg::dp_stat_t  stat,
	output lcdr_pkg::ctl_cmd_t  cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_FILL = 5'b00100,
		ST_COPY = 5'b01000,
		ST_SCAN = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (lcdr_pkg::cmd_t'(command))
						lcdr_pkg::CMD_WRITE: begin
							cmd.cell_wr  = 1'b1;
							cmd.res_none = 1'b1;
							done_d       = 1'b1;
						end
						lcdr_pkg::CMD_CLEAR: begin
							state_d = ST_FILL;
						end
						lcdr_pkg::CMD_SYNC: begin
							cmd.sync_set = 1'b1;
							state_d      = ST_COPY;
						end
						lcdr_pkg::CMD_TICK: begin
							if (!stat.dirty) begin
								cmd.res_none = 1'b1;
								done_d       = 1'b1;
							end else if (!stat.xfer_idle) begin
								cmd.tick_step = 1'b1;
								done_d        = 1'b1;
							end else begin
								cmd.scan_load = 1'b1;
								state_d       = ST_SCAN;
							end
						end
						default: begin
							cmd.res_none = 1'b1;
							done_d       = 1'b1;
						end
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_sweep = 1'b1;
				if (stat.sweep_last) begin
					cmd.res_none = 1'b1;
					done_d       = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_COPY: begin
				cmd.copy_sweep = 1'b1;
				if (stat.sweep_last) begin
					cmd.res_none = 1'b1;
					done_d       = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_hit || stat.scan_miss) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// Scan ends on a hit or a clean pass, with a result
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && (stat.scan_hit || stat.scan_miss)) |=>
			(state_q == ST_IDLE && done_q))
		else $error("scan end without result");

	// No result during the reset clearing pass
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !done_q)
		else $error("result during clearing pass");

	// Hit and clean-pass are exclusive
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.scan_hit && stat.scan_miss))
		else $error("scan hit and miss together");

endmodule

// ===== hw/rtl/char_lcd_diff_refresh_core.sv =====
// Top level of the character LCD refresh engine (4x20 panel).
// Instantiates lcdr_ctrl and lcdr_dp; uses lcdr_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  request  | start in, busy out  | command, row, col, char_code, busy_flag
//  result   | done out (1 cycle)  | bus_action, bus_data, refresh_pending
//
// Cell write, clean tick and tick during a transfer: result in the cycle after
// acceptance. Clear and sync: sweep over the user frame memory port.
// Scanning tick: one frame memory read per cycle. After reset a clearing pass
// runs with busy high. The result strobe cannot be held off; the next request
// may be taken at the edge that ends the strobe cycle.
module char_lcd_diff_refresh_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [1:0] row,
	input  logic [4:0] col,
	input  logic [7:0] char_code,
	input  logic       busy_flag,
	output logic       done,
	output logic [1:0] bus_action,
	output logic [7:0] bus_data,
	output logic       refresh_pending
);

	lcdr_pkg::ctl_cmd_t ctl_cmd;
	lcdr_pkg::dp_stat_t dp_stat;

	// Sequencer
	lcdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (dp_stat),
		.cmd     (ctl_cmd),
		.busy    (busy),
		.done    (done)
	);

	// Frames, counters and result registers
	lcdr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctl_cmd),
		.row             (row),
		.col             (col),
		.char_code       (char_code),
		.busy_flag       (busy_flag),
		.stat            (dp_stat),
		.bus_action      (bus_action),
		.bus_data        (bus_data),
		.refresh_pending (refresh_pending)
	);

endmodule

// ===== sim/testbench.sv =====
// Testbench for char_lcd_diff_refresh_core: directed table, then random host traffic.
// Every result is checked against an in-bench model of the refresh engine or a hand-typed bus cycle.
// Depends on lcdr_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;
	import lcdr_pkg::*;

	localparam int RANDOM_REQUESTS = 450;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 100;
	localparam int TABLE_ROWS      = 25;

	// One panel bus cycle as seen on the result ports
	typedef struct packed {
		act_t       act;
		logic [7:0] data;
		logic       pend;
	} bus_cycle_t;

	// Directed request with an optional hand-typed bus cycle
	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] row;
		logic [4:0] col;
		logic [7:0] ch;
		logic       bflag;
		logic       typed;
		bus_cycle_t res;
	} table_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	cmd_t       command;
	logic [1:0] row;
	logic [4:0] col;
	logic [7:0] char_code;
	logic       busy_flag;
	logic       done;
	logic [1:0] bus_action;
	logic [7:0] bus_data;
	logic       refresh_pending;

	// Panel model state
	logic [7:0] user_fr    [CELLS];
	logic [7:0] desired_fr [CELLS];
	logic [7:0] shadow_fr  [CELLS];
	logic       lcd_dirty;
	phase_t     lcd_phase;
	int         scan_r;
	int         scan_c;
	logic [7:0] last_addr;
	logic [7:0] pending_ch;

	bus_cycle_t panel_bus_q [$];
	bus_cycle_t seen_cycle;
	int         errors;
	int         idle_cycles;

	// Directed table: clean tick, range edges, set-address and direct-data paths,
	// busy polling, sync in the middle of a transfer, clear to spaces
	table_row_t stim_table [TABLE_ROWS] = '{
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_WRITE, 2'd0, 5'd0,  8'h41, 1'b1, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_WRITE, 2'd0, 5'd1,  8'h42, 1'b0, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_WRITE, 2'd3, 5'd19, 8'hff, 1'b0, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_WRITE, 2'd2, 5'd31, 8'h55, 1'b0, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_WRITE, 2'd1, 5'd20, 8'haa, 1'b1, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_SYNC,  2'd3, 5'd31, 8'hff, 1'b1, 1'b1, '{ACT_NONE,  8'h00, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_INSTR, 8'h80, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b1, 1'b1, '{ACT_BUSY,  8'h00, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_BUSY,  8'h00, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_DATA,  8'h41, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_BUSY,  8'h00, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_DATA,  8'h42, 1'b1}},
		'{CMD_SYNC,  2'd0, 5'd0,  8'h00, 1'b0, 1'b1, '{ACT_NONE,  8'h00, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b1, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_CLEAR, 2'd2, 5'd7,  8'h13, 1'b1, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b1, 1'b1, '{ACT_NONE,  8'h00, 1'b0}},
		'{CMD_SYNC,  2'd1, 5'd3,  8'h00, 1'b0, 1'b1, '{ACT_NONE,  8'h00, 1'b1}},
		'{CMD_TICK,  2'd0, 5'd0,  8'h00, 1'b0, 1'b0, '{ACT_NONE,  8'h00, 1'b0}}
	};

	char_lcd_diff_refresh_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.row             (row),
		.col             (col),
		.char_code       (char_code),
		.busy_flag       (busy_flag),
		.done            (done),
		.bus_action      (bus_action),
		.bus_data        (bus_data),
		.refresh_pending (refresh_pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Advance the panel model by one request and return the bus cycle it drives
	function automatic void step_panel_model(input cmd_t cmd, input logic [1:0] r,
			input logic [4:0] c, input logic [7:0] ch, input logic bflag,
			output bus_cycle_t res);
		int         rr;
		int         cc;
		int         hit_r;
		int         hit_c;
		int         idx;
		bit         found;
		logic [7:0] addr;
		res = '{ACT_NONE, 8'h00, 1'b0};
		case (cmd)
			CMD_WRITE: begin
				if (int'(r) < ROWS && int'(c) < COLUMNS) begin
					user_fr[int'(r) * COLUMNS + int'(c)] = ch;
				end
			end
			CMD_CLEAR: begin
				foreach (user_fr[i]) user_fr[i] = SPACE_CHAR;
			end
			CMD_SYNC: begin
				desired_fr = user_fr;
				lcd_dirty  = 1'b1;
				scan_r     = 0;
				scan_c     = 0;
			end
			default: begin
				if (lcd_dirty) begin
					// idle: look for the next cell where desired and shadow differ
					if (lcd_phase == PH_IDLE) begin
						found = 1'b0;
						hit_r = 0;
						hit_c = 0;
						for (rr = scan_r; rr < ROWS && !found; rr++) begin
							for (cc = (rr == scan_r) ? scan_c : 0; cc < COLUMNS && !found;
									cc++) begin
								if (desired_fr[rr * COLUMNS + cc] != shadow_fr[rr * COLUMNS + cc]) begin
									found = 1'b1;
									hit_r = rr;
									hit_c = cc;
								end
							end
						end
						if (!found) begin
							scan_r    = 0;
							scan_c    = 0;
							lcd_dirty = 1'b0;
						end else begin
							idx  = hit_r * COLUMNS + hit_c;
							addr = 8'(hit_r * 64 + hit_c);
							if (hit_r > 1) addr = addr - ADDR_HI_ADJ;
							shadow_fr[idx] = desired_fr[idx];
							scan_r = hit_r;
							scan_c = hit_c;
							// address following the last one needs no set-address
							if ({1'b0, addr} == {1'b0, last_addr} + 9'd1) lcd_phase = PH_DATA;
							else lcd_phase = PH_ADDR;
							last_addr  = addr;
							pending_ch = desired_fr[idx];
						end
					end
					// transfer steps
					if (lcd_phase == PH_ADDR) begin
						res.act   = ACT_INSTR;
						res.data  = SET_ADDR_OP | last_addr;
						lcd_phase = PH_ADDR_WAIT;
					end else if (lcd_phase == PH_DATA) begin
						res.act   = ACT_DATA;
						res.data  = pending_ch;
						lcd_phase = PH_DATA_WAIT;
					end else if (lcd_phase == PH_ADDR_WAIT || lcd_phase == PH_DATA_WAIT) begin
						res.act = ACT_BUSY;
						if (!bflag) lcd_phase = (lcd_phase == PH_ADDR_WAIT) ? PH_DATA : PH_IDLE;
					end
				end
			end
		endcase
		res.pend = lcd_dirty;
	endfunction

	// Hand one request to the block after a random gap and record its bus cycle
	task automatic issue_request(input cmd_t cmd, input logic [1:0] r, input logic [4:0] c,
			input logic [7:0] ch, input logic bflag, input logic typed,
			input bus_cycle_t typed_res);
		int         gap;
		logic       stalled;
		bus_cycle_t res;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		command   <= cmd;
		row       <= r;
		col       <= c;
		char_code <= ch;
		busy_flag <= bflag;
		// busy only moves at the rising edge, so its mid-cycle value decides the edge
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
		step_panel_model(cmd, r, c, ch, bflag, res);
		panel_bus_q.push_back(typed ? typed_res : res);
	endtask

	// Result check, once per strobe
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (panel_bus_q.size() == 0) begin
				$error("unexpected result: bus_action %0d bus_data %02h", bus_action, bus_data);
				errors++;
			end else begin
				seen_cycle = panel_bus_q.pop_front();
				if (bus_action !== seen_cycle.act) begin
					$error("bus_action: expected %0d, got %0d", seen_cycle.act, bus_action);
					errors++;
				end
				if (bus_data !== seen_cycle.data) begin
					$error("bus_data: expected %02h, got %02h", seen_cycle.data, bus_data);
					errors++;
				end
				if (refresh_pending !== seen_cycle.pend) begin
					$error("refresh_pending: expected %0d, got %0d", seen_cycle.pend,
						refresh_pending);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no request taken and no result
	always @(negedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no progress for %0d cycles, %0d results outstanding", idle_cycles,
				panel_bus_q.size());
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int         pick;
		int         run_row;
		int         run_col;
		cmd_t       rcmd;
		logic [1:0] rrow;
		logic [4:0] rcol;
		logic [7:0] rch;
		logic       rbf;
		errors      = 0;
		idle_cycles = 0;
		run_row     = 0;
		run_col     = 0;
		foreach (user_fr[i]) begin
			user_fr[i]    = 8'h00;
			desired_fr[i] = 8'h00;
			shadow_fr[i]  = 8'h00;
		end
		lcd_dirty  = 1'b0;
		lcd_phase  = PH_IDLE;
		scan_r     = 0;
		scan_c     = 0;
		last_addr  = 8'h00;
		pending_ch = 8'h00;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		command   <= CMD_WRITE;
		row       <= 2'd0;
		col       <= 5'd0;
		char_code <= 8'h00;
		busy_flag <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (stim_table[i]) begin
			issue_request(stim_table[i].cmd, stim_table[i].row, stim_table[i].col,
				stim_table[i].ch, stim_table[i].bflag, stim_table[i].typed, stim_table[i].res);
		end

		// random host traffic: mostly ticks and cell writes, runs of adjacent cells
		repeat (RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			rrow = 2'($urandom_range(0, 3));
			rcol = 5'($urandom_range(0, 31));
			rch  = 8'($urandom);
			rbf  = ($urandom_range(0, 3) == 0);
			if (pick < 5) begin
				rcmd = CMD_CLEAR;
			end else if (pick < 14) begin
				rcmd = CMD_SYNC;
			end else if (pick < 42) begin
				rcmd = CMD_WRITE;
				if ($urandom_range(0, 1) == 1 && run_col < COLUMNS - 1) begin
					run_col = run_col + 1;
				end else if ($urandom_range(0, 7) == 0) begin
					run_row = $urandom_range(0, 3);
					run_col = $urandom_range(COLUMNS, 31);
				end else begin
					run_row = $urandom_range(0, ROWS - 1);
					run_col = $urandom_range(0, COLUMNS - 1);
				end
				rrow = 2'(run_row);
				rcol = 5'(run_col);
			end else begin
				rcmd = CMD_TICK;
			end
			issue_request(rcmd, rrow, rcol, rch, rbf, 1'b0, '0);
		end
		start <= 1'b0;

		while (panel_bus_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
